// ----- rtl/futex_wait_queue_engine_macros.svh -----
// Assertion macros for the futex wait queue engine.
// Included by the files that assert; no other dependencies.
`ifndef FUTEX_WAIT_QUEUE_ENGINE_MACROS_SVH
`define FUTEX_WAIT_QUEUE_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define FWQ_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("fwq same-cycle check failed");
// next-cycle implication
`define FWQ_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("fwq next-cycle check failed");
`else
`define FWQ_ASSERT_IMP(label, clk, rstn, ante, cons)
`define FWQ_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

// ----- rtl/fwq_pkg.sv -----
// Shared types and constants of the futex wait queue engine.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fwq_pkg;

    localparam int KEY_ENTRIES    = 16;
    localparam int WAITER_SLOTS   = 32;
    localparam int WAITER_ID_BITS = 8;

    localparam int ENTRY_W  = $clog2(KEY_ENTRIES);
    localparam int SLOT_W   = $clog2(WAITER_SLOTS);
    localparam int LEN_W    = $clog2(WAITER_SLOTS + 1);
    localparam int SCAN_SW  = $clog2(WAITER_SLOTS + 1);
    localparam int SCAN_KW  = $clog2(KEY_ENTRIES + 1);
    localparam int SCAN_W   = (SCAN_SW > SCAN_KW) ? SCAN_SW : SCAN_KW;
    localparam int IDX_W    = (SLOT_W > ENTRY_W) ? SLOT_W : ENTRY_W;
    localparam int COUNT_W  = 6;
    localparam int IN_DATA_W  = 400;
    localparam int OUT_DATA_W = 24;

    typedef enum logic [1:0] {
        CMD_WAIT, CMD_WAKE, CMD_REQUEUE, CMD_WITHDRAW
    } cmd_t;

    typedef enum logic [2:0] {
        STS_OK, STS_MISMATCH, STS_NO_ROOM, STS_TIMED_OUT, STS_DUPLICATE
    } status_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DUP, ST_KEY, ST_AP_RD, ST_AP_WR, ST_AP_LINK, ST_REQ_CHK,
        ST_W_HD, ST_W_LD, ST_W_CHK, ST_W_RD, ST_W_OUT,
        ST_M_HD, ST_M_LD, ST_M_CHK, ST_M_RD, ST_M_WR, ST_M_LINK,
        ST_T_WB, ST_E_WB, ST_X_HD, ST_X_LD, ST_X_WALK, ST_X_STEP, ST_X_FIX,
        ST_FINAL
    } fsm_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] space;
        logic [63:0] offset;
    } key_t;

    typedef struct packed {
        key_t              key;
        logic [SLOT_W-1:0] head;
        logic [SLOT_W-1:0] tail;
    } entry_t;

    typedef struct packed {
        logic [WAITER_ID_BITS-1:0] waiter;
        logic [SLOT_W-1:0]         next;
        logic [ENTRY_W-1:0]        entry;
    } slot_t;

    // input transaction layout, first field in the lowest bits
    typedef struct packed {
        logic [3:0]  pad;
        logic [31:0] requeue_limit;
        logic [31:0] wake_limit;
        logic [31:0] observed_value;
        logic [31:0] expected_value;
        logic [7:0]  waiter_id;
        logic [63:0] target_offset;
        logic [63:0] target_space;
        logic [1:0]  target_kind;
        logic [63:0] key_offset;
        logic [63:0] key_space;
        logic [1:0]  key_kind;
    } in_data_t;

    // slot pool request and response
    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        logic              wr_waiter_en;
        logic              wr_next_en;
        logic              wr_entry_en;
        slot_t             wr_data;
        logic              use_en;
        logic              use_set;
        logic [SLOT_W-1:0] use_idx;
    } slot_req_t;

    typedef struct packed {
        slot_t             q;
        logic              q_used;
        logic              free_vld;
        logic [SLOT_W-1:0] free_idx;
    } slot_rsp_t;

endpackage
`default_nettype wire

// ----- rtl/fwq_slot_pool.sv -----
// Waiter slot pool: slot memory with field writes, in-use flags, free slot pick.
// Depends on fwq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fwq_slot_pool import fwq_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire slot_req_t req,
    output slot_rsp_t      rsp
);

    slot_t                   mem [WAITER_SLOTS];
    slot_t                   q_reg;
    logic                    q_used_reg;
    logic [WAITER_SLOTS-1:0] used_reg;

    // slot memory, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            if (req.wr_waiter_en) mem[req.wr_addr].waiter <= req.wr_data.waiter;
            if (req.wr_next_en)   mem[req.wr_addr].next   <= req.wr_data.next;
            if (req.wr_entry_en)  mem[req.wr_addr].entry  <= req.wr_data.entry;
        end
        if (req.rd_en) begin
            q_reg      <= mem[req.rd_addr];
            q_used_reg <= used_reg[req.rd_addr];
        end
    end

    // in-use flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
        end else if (req.use_en) begin
            used_reg[req.use_idx] <= req.use_set;
        end
    end

    // lowest free slot
    always_comb begin
        rsp.free_vld = 1'b0;
        rsp.free_idx = '0;
        for (int i = WAITER_SLOTS - 1; i >= 0; i--) begin
            if (!used_reg[i]) begin
                rsp.free_vld = 1'b1;
                rsp.free_idx = SLOT_W'(i);
            end
        end
        rsp.q      = q_reg;
        rsp.q_used = q_used_reg;
    end

endmodule
`default_nettype wire

// ----- rtl/futex_wait_queue_engine.sv -----
// Futex wait queue engine: one command at a time, state in entry and slot memories.
// Wait scans the slots for a duplicate id, then the key table, then appends; wake
// scans the key table and reports each waiter woken; requeue adds a target scan and
// moves waiters; withdraw walks the queue to unlink. The scans read one entry a cycle.
// Throughput: one command at a time; the next is taken once the final status is loaded.
// Reset: synchronous active low, clears control, entry valid bits, lengths and slot flags.
`timescale 1ns / 1ps
`default_nettype none
`include "futex_wait_queue_engine_macros.svh"
module futex_wait_queue_engine import fwq_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // key_kind, key_space, key_offset, target_kind, target_space, target_offset,
    // waiter_id, expected_value, observed_value, wake_limit, requeue_limit, zero pad
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // command
    input  wire logic [1:0]            s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // woken_waiter, status, affected_count, zero pad
    output logic [OUT_DATA_W-1:0]      m_tdata,
    // result_kind
    output logic                       m_tuser,
    output logic                       m_tlast
);

    in_data_t  in_d;
    slot_req_t sreq;
    slot_rsp_t srsp;

    fsm_t state_reg, state_next;
    cmd_t cmd_reg, cmd_next;
    key_t src_reg, src_next, tgt_reg, tgt_next;
    logic [WAITER_ID_BITS-1:0] id_reg, id_next;
    logic [31:0] wlimit_reg, wlimit_next, rlimit_reg, rlimit_next;
    logic [ENTRY_W-1:0] e_reg, e_next, t_reg, t_next;
    logic new_reg, new_next;
    logic [SLOT_W-1:0] fs_reg, fs_next, tail_reg, tail_next;
    logic [SLOT_W-1:0] head_e_reg, head_e_next, head_t_reg, head_t_next;
    logic [SLOT_W-1:0] cur_reg, cur_next, prev_reg, prev_next, nexts_reg, nexts_next;
    logic prev_vld_reg, prev_vld_next;
    logic [LEN_W-1:0] n_reg, n_next;
    logic [SCAN_W-1:0] scan_reg, scan_next;
    logic chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0] chk_idx_reg, chk_idx_next;
    logic tsel_reg, tsel_next;
    logic [COUNT_W-1:0] woken_reg, woken_next, moved_reg, moved_next;
    logic [COUNT_W-1:0] migrate_reg, migrate_next;
    logic same_reg, same_next, move_go_reg, move_go_next;
    status_t status_reg, status_next;

    logic m_valid_reg, m_valid_next, m_kind_reg, m_kind_next, m_last_reg, m_last_next;
    logic [7:0] m_woken_reg, m_woken_next;
    status_t m_status_reg, m_status_next;
    logic [COUNT_W-1:0] m_count_reg, m_count_next;

    // entry table: key and queue pointers in memory, valid and length in flops
    entry_t emem [KEY_ENTRIES];
    entry_t emem_q_reg;
    logic [KEY_ENTRIES-1:0] valid_reg;
    logic [LEN_W-1:0] qlen_reg [KEY_ENTRIES];

    logic em_rd_en, em_wr_en, em_key_en, em_head_en, em_tail_en;
    logic [ENTRY_W-1:0] em_rd_addr, em_wr_addr;
    entry_t em_wr_data;
    logic ent_make_en, ent_inc_en, ent_dec_en;
    logic [ENTRY_W-1:0] ent_make_idx, ent_inc_idx;
    logic ent_free_vld;
    logic [ENTRY_W-1:0] ent_free_idx;

    logic accept, out_free, slot_hit, slot_miss, key_hit, key_miss;
    logic [31:0] len32, rest32, mig32;
    logic [LEN_W-1:0] len_e, len_t;

    assign in_d     = in_data_t'(s_tdata);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign len_e    = qlen_reg[e_reg];
    assign len_t    = qlen_reg[t_reg];

    fwq_slot_pool u_pool (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (sreq),
        .rsp     (srsp)
    );

    // entry memory
    always_ff @(posedge aclk) begin
        if (em_wr_en) begin
            if (em_key_en)  emem[em_wr_addr].key  <= em_wr_data.key;
            if (em_head_en) emem[em_wr_addr].head <= em_wr_data.head;
            if (em_tail_en) emem[em_wr_addr].tail <= em_wr_data.tail;
        end
        if (em_rd_en) begin
            emem_q_reg <= emem[em_rd_addr];
        end
    end

    // entry valid bits and queue lengths
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            for (int i = 0; i < KEY_ENTRIES; i++) qlen_reg[i] <= '0;
        end else begin
            if (ent_make_en) begin
                valid_reg[ent_make_idx] <= 1'b1;
                qlen_reg[ent_make_idx]  <= '0;
            end
            if (ent_inc_en) begin
                valid_reg[ent_inc_idx] <= 1'b1;
                qlen_reg[ent_inc_idx]  <= qlen_reg[ent_inc_idx] + 1'b1;
            end
            if (ent_dec_en) begin
                if (qlen_reg[e_reg] != '0) qlen_reg[e_reg] <= qlen_reg[e_reg] - 1'b1;
                if (qlen_reg[e_reg] <= LEN_W'(1)) valid_reg[e_reg] <= 1'b0;
            end
        end
    end

    // lowest free entry
    always_comb begin
        ent_free_vld = 1'b0;
        ent_free_idx = '0;
        for (int i = KEY_ENTRIES - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                ent_free_vld = 1'b1;
                ent_free_idx = ENTRY_W'(i);
            end
        end
    end

    // scan compare on the data read in the previous cycle
    assign slot_hit  = chk_vld_reg && srsp.q_used && (srsp.q.waiter == id_reg);
    assign slot_miss = !chk_vld_reg && (scan_reg >= SCAN_W'(WAITER_SLOTS));
    assign key_hit   = chk_vld_reg && valid_reg[chk_idx_reg[ENTRY_W-1:0]]
                       && (emem_q_reg.key == (tsel_reg ? tgt_reg : src_reg));
    assign key_miss  = !chk_vld_reg && (scan_reg >= SCAN_W'(KEY_ENTRIES));

    // requeue split of the remaining queue
    assign len32  = 32'(len_e);
    assign rest32 = (len32 > wlimit_reg) ? (len32 - wlimit_reg) : 32'd0;
    assign mig32  = (rest32 < rlimit_reg) ? rest32 : rlimit_reg;

    // sequencer: next state and memory controls
    always_comb begin
        state_next = state_reg;   cmd_next = cmd_reg;
        src_next = src_reg;       tgt_next = tgt_reg;       id_next = id_reg;
        wlimit_next = wlimit_reg; rlimit_next = rlimit_reg;
        e_next = e_reg;           t_next = t_reg;           new_next = new_reg;
        fs_next = fs_reg;         tail_next = tail_reg;
        head_e_next = head_e_reg; head_t_next = head_t_reg;
        cur_next = cur_reg;       prev_next = prev_reg;     nexts_next = nexts_reg;
        prev_vld_next = prev_vld_reg; n_next = n_reg;
        scan_next = scan_reg;     chk_vld_next = 1'b0;      chk_idx_next = chk_idx_reg;
        tsel_next = tsel_reg;     woken_next = woken_reg;   moved_next = moved_reg;
        migrate_next = migrate_reg; same_next = same_reg;   move_go_next = move_go_reg;
        status_next = status_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_kind_next = m_kind_reg; m_last_next = m_last_reg;
        m_woken_next = m_woken_reg; m_status_next = m_status_reg;
        m_count_next = m_count_reg;

        em_rd_en = 1'b0; em_rd_addr = e_reg;
        em_wr_en = 1'b0; em_wr_addr = e_reg;
        em_key_en = 1'b0; em_head_en = 1'b0; em_tail_en = 1'b0;
        em_wr_data = '{key: src_reg, head: fs_reg, tail: fs_reg};
        ent_make_en = 1'b0; ent_make_idx = t_reg;
        ent_inc_en = 1'b0;  ent_inc_idx = e_reg;
        ent_dec_en = 1'b0;
        sreq = '0;
        sreq.rd_addr = head_e_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd_next = cmd_t'(s_tuser);
                    src_next = '{kind: in_d.key_kind, space: in_d.key_space,
                                 offset: in_d.key_offset};
                    tgt_next = '{kind: in_d.target_kind, space: in_d.target_space,
                                 offset: in_d.target_offset};
                    id_next = in_d.waiter_id[WAITER_ID_BITS-1:0];
                    wlimit_next = in_d.wake_limit;
                    rlimit_next = in_d.requeue_limit;
                    woken_next = '0; moved_next = '0; migrate_next = '0;
                    same_next = 1'b0; move_go_next = 1'b0; status_next = STS_OK;
                    scan_next = '0; tsel_next = 1'b0;
                    case (cmd_t'(s_tuser))
                        CMD_WAIT: begin
                            if (in_d.observed_value != in_d.expected_value) begin
                                status_next = STS_MISMATCH;
                                state_next = ST_FINAL;
                            end else begin
                                state_next = ST_DUP;
                            end
                        end
                        CMD_WITHDRAW: state_next = ST_DUP;
                        default:      state_next = ST_KEY;
                    endcase
                end
            end
            // scan slots for the waiter id
            ST_DUP: begin
                if (scan_reg < SCAN_W'(WAITER_SLOTS)) begin
                    sreq.rd_en = 1'b1;
                    sreq.rd_addr = scan_reg[SLOT_W-1:0];
                    chk_vld_next = 1'b1;
                    chk_idx_next = IDX_W'(scan_reg[SLOT_W-1:0]);
                    scan_next = scan_reg + 1'b1;
                end
                if (slot_hit) begin
                    chk_vld_next = 1'b0;
                    if (cmd_reg == CMD_WAIT) begin
                        status_next = STS_DUPLICATE;
                        state_next = ST_FINAL;
                    end else begin
                        fs_next = chk_idx_reg[SLOT_W-1:0];
                        e_next = srsp.q.entry;
                        nexts_next = srsp.q.next;
                        state_next = ST_X_HD;
                    end
                end else if (slot_miss) begin
                    if (cmd_reg == CMD_WAIT) begin
                        scan_next = '0;
                        tsel_next = 1'b0;
                        state_next = ST_KEY;
                    end else begin
                        state_next = ST_FINAL;
                    end
                end
            end
            // scan the key table for source or target key
            ST_KEY: begin
                if (scan_reg < SCAN_W'(KEY_ENTRIES)) begin
                    em_rd_en = 1'b1;
                    em_rd_addr = scan_reg[ENTRY_W-1:0];
                    chk_vld_next = 1'b1;
                    chk_idx_next = IDX_W'(scan_reg[ENTRY_W-1:0]);
                    scan_next = scan_reg + 1'b1;
                end
                if (key_hit || key_miss) begin
                    chk_vld_next = 1'b0;
                    if (tsel_reg) begin
                        if (key_hit) begin
                            t_next = chk_idx_reg[ENTRY_W-1:0];
                            state_next = ST_W_HD;
                        end else if (ent_free_vld) begin
                            t_next = ent_free_idx;
                            ent_make_en = 1'b1;
                            ent_make_idx = ent_free_idx;
                            em_wr_en = 1'b1;
                            em_wr_addr = ent_free_idx;
                            em_key_en = 1'b1;
                            em_wr_data.key = tgt_reg;
                            state_next = ST_W_HD;
                        end else begin
                            status_next = STS_NO_ROOM;
                            state_next = ST_FINAL;
                        end
                    end else if (cmd_reg == CMD_WAIT) begin
                        fs_next = srsp.free_idx;
                        if (key_hit && srsp.free_vld) begin
                            e_next = chk_idx_reg[ENTRY_W-1:0];
                            new_next = 1'b0;
                            state_next = ST_AP_RD;
                        end else if (key_miss && srsp.free_vld && ent_free_vld) begin
                            e_next = ent_free_idx;
                            new_next = 1'b1;
                            state_next = ST_AP_RD;
                        end else begin
                            status_next = STS_NO_ROOM;
                            state_next = ST_FINAL;
                        end
                    end else if (key_hit) begin
                        e_next = chk_idx_reg[ENTRY_W-1:0];
                        state_next = (cmd_reg == CMD_REQUEUE) ? ST_REQ_CHK : ST_W_HD;
                    end else begin
                        state_next = ST_FINAL;
                    end
                end
            end
            // append a new waiter at the tail
            ST_AP_RD: begin
                em_rd_en = 1'b1;
                state_next = ST_AP_WR;
            end
            ST_AP_WR: begin
                sreq.wr_en = 1'b1;
                sreq.wr_addr = fs_reg;
                sreq.wr_waiter_en = 1'b1;
                sreq.wr_next_en = 1'b1;
                sreq.wr_entry_en = 1'b1;
                sreq.wr_data = '{waiter: id_reg, next: '0, entry: e_reg};
                sreq.use_en = 1'b1;
                sreq.use_set = 1'b1;
                sreq.use_idx = fs_reg;
                em_wr_en = 1'b1;
                em_key_en = new_reg;
                em_head_en = (len_e == '0);
                em_tail_en = 1'b1;
                ent_inc_en = 1'b1;
                tail_next = emem_q_reg.tail;
                state_next = (len_e == '0) ? ST_FINAL : ST_AP_LINK;
            end
            ST_AP_LINK: begin
                sreq.wr_en = 1'b1;
                sreq.wr_addr = tail_reg;
                sreq.wr_next_en = 1'b1;
                sreq.wr_data.next = fs_reg;
                state_next = ST_FINAL;
            end
            // requeue split and target decision
            ST_REQ_CHK: begin
                same_next = (src_reg == tgt_reg);
                migrate_next = COUNT_W'(mig32);
                move_go_next = (src_reg != tgt_reg) && (mig32 != 32'd0);
                if ((src_reg != tgt_reg) && (mig32 != 32'd0)) begin
                    scan_next = '0;
                    tsel_next = 1'b1;
                    state_next = ST_KEY;
                end else begin
                    state_next = ST_W_HD;
                end
            end
            // wake from the head
            ST_W_HD: begin
                em_rd_en = 1'b1;
                state_next = ST_W_LD;
            end
            ST_W_LD: begin
                head_e_next = emem_q_reg.head;
                state_next = ST_W_CHK;
            end
            ST_W_CHK: begin
                if ((32'(woken_reg) < wlimit_reg) && (len_e != '0)) begin
                    state_next = ST_W_RD;
                end else begin
                    state_next = move_go_reg ? ST_M_HD : ST_E_WB;
                end
            end
            ST_W_RD: begin
                sreq.rd_en = 1'b1;
                state_next = ST_W_OUT;
            end
            ST_W_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next = 1'b0;
                    m_last_next = 1'b0;
                    m_woken_next = 8'(srsp.q.waiter);
                    m_status_next = STS_OK;
                    m_count_next = woken_reg + 1'b1;
                    woken_next = woken_reg + 1'b1;
                    head_e_next = srsp.q.next;
                    ent_dec_en = 1'b1;
                    sreq.use_en = 1'b1;
                    sreq.use_set = 1'b0;
                    sreq.use_idx = head_e_reg;
                    state_next = ST_W_CHK;
                end
            end
            // move remaining waiters to the target tail
            ST_M_HD: begin
                em_rd_en = 1'b1;
                em_rd_addr = t_reg;
                state_next = ST_M_LD;
            end
            ST_M_LD: begin
                head_t_next = emem_q_reg.head;
                tail_next = emem_q_reg.tail;
                state_next = ST_M_CHK;
            end
            ST_M_CHK: begin
                if ((moved_reg < migrate_reg) && (len_e != '0)) begin
                    state_next = ST_M_RD;
                end else begin
                    state_next = ST_T_WB;
                end
            end
            ST_M_RD: begin
                sreq.rd_en = 1'b1;
                state_next = ST_M_WR;
            end
            ST_M_WR: begin
                cur_next = head_e_reg;
                head_e_next = srsp.q.next;
                sreq.wr_en = 1'b1;
                sreq.wr_addr = head_e_reg;
                sreq.wr_next_en = 1'b1;
                sreq.wr_entry_en = 1'b1;
                sreq.wr_data = '{waiter: '0, next: '0, entry: t_reg};
                ent_dec_en = 1'b1;
                ent_inc_en = 1'b1;
                ent_inc_idx = t_reg;
                moved_next = moved_reg + 1'b1;
                if (len_t == '0) begin
                    head_t_next = head_e_reg;
                    tail_next = head_e_reg;
                    state_next = ST_M_CHK;
                end else begin
                    state_next = ST_M_LINK;
                end
            end
            ST_M_LINK: begin
                sreq.wr_en = 1'b1;
                sreq.wr_addr = tail_reg;
                sreq.wr_next_en = 1'b1;
                sreq.wr_data.next = cur_reg;
                tail_next = cur_reg;
                state_next = ST_M_CHK;
            end
            // write back queue pointers
            ST_T_WB: begin
                em_wr_en = 1'b1;
                em_wr_addr = t_reg;
                em_head_en = 1'b1;
                em_tail_en = 1'b1;
                em_wr_data.head = head_t_reg;
                em_wr_data.tail = tail_reg;
                state_next = ST_E_WB;
            end
            ST_E_WB: begin
                em_wr_en = 1'b1;
                em_head_en = 1'b1;
                em_wr_data.head = head_e_reg;
                state_next = ST_FINAL;
            end
            // withdraw: walk to the slot and unlink it
            ST_X_HD: begin
                em_rd_en = 1'b1;
                state_next = ST_X_LD;
            end
            ST_X_LD: begin
                cur_next = emem_q_reg.head;
                tail_next = emem_q_reg.tail;
                prev_vld_next = 1'b0;
                n_next = '0;
                state_next = ST_X_WALK;
            end
            ST_X_WALK: begin
                if ((n_reg < len_e) && (cur_reg != fs_reg)) begin
                    sreq.rd_en = 1'b1;
                    sreq.rd_addr = cur_reg;
                    state_next = ST_X_STEP;
                end else begin
                    state_next = ST_X_FIX;
                end
            end
            ST_X_STEP: begin
                prev_next = cur_reg;
                prev_vld_next = 1'b1;
                cur_next = srsp.q.next;
                n_next = n_reg + 1'b1;
                state_next = ST_X_WALK;
            end
            ST_X_FIX: begin
                if (!prev_vld_reg) begin
                    em_wr_en = 1'b1;
                    em_head_en = 1'b1;
                    em_wr_data.head = nexts_reg;
                end else begin
                    sreq.wr_en = 1'b1;
                    sreq.wr_addr = prev_reg;
                    sreq.wr_next_en = 1'b1;
                    sreq.wr_data.next = nexts_reg;
                    if (tail_reg == fs_reg) begin
                        em_wr_en = 1'b1;
                        em_tail_en = 1'b1;
                        em_wr_data.tail = prev_reg;
                    end
                end
                ent_dec_en = 1'b1;
                sreq.use_en = 1'b1;
                sreq.use_set = 1'b0;
                sreq.use_idx = fs_reg;
                status_next = STS_TIMED_OUT;
                state_next = ST_FINAL;
            end
            // final status transaction
            ST_FINAL: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next = 1'b1;
                    m_last_next = 1'b1;
                    m_woken_next = '0;
                    m_status_next = status_reg;
                    m_count_next = woken_reg + moved_reg + (same_reg ? migrate_reg : '0)
                                   + COUNT_W'(status_reg == STS_TIMED_OUT);
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            e_reg       <= '0;
            chk_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            e_reg       <= e_next;
            chk_vld_reg <= chk_vld_next;
        end
    end

    // working and payload registers
    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;       src_reg <= src_next;       tgt_reg <= tgt_next;
        id_reg <= id_next;         wlimit_reg <= wlimit_next; rlimit_reg <= rlimit_next;
        t_reg <= t_next;           new_reg <= new_next;       fs_reg <= fs_next;
        tail_reg <= tail_next;     head_e_reg <= head_e_next; head_t_reg <= head_t_next;
        cur_reg <= cur_next;       prev_reg <= prev_next;     nexts_reg <= nexts_next;
        prev_vld_reg <= prev_vld_next; n_reg <= n_next;       scan_reg <= scan_next;
        chk_idx_reg <= chk_idx_next;   tsel_reg <= tsel_next; woken_reg <= woken_next;
        moved_reg <= moved_next;   migrate_reg <= migrate_next; same_reg <= same_next;
        move_go_reg <= move_go_next; status_reg <= status_next;
        m_kind_reg <= m_kind_next; m_last_reg <= m_last_next; m_woken_reg <= m_woken_next;
        m_status_reg <= m_status_next; m_count_reg <= m_count_next;
    end

    // result port
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {7'b0, m_count_reg, m_status_reg, m_woken_reg};

    // checks
    `FWQ_ASSERT_NXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `FWQ_ASSERT_IMP(a_valid_len_idle, aclk, aresetn, state_reg == ST_IDLE,
        valid_reg[e_reg] == (qlen_reg[e_reg] != '0))
    `FWQ_ASSERT_IMP(a_report_not_last, aclk, aresetn, m_tvalid && !m_tuser, !m_tlast)

endmodule
`default_nettype wire

// ----- sim/futex_wait_queue_engine_checker.sv -----
// Checker for the futex wait queue engine: watches both stream channels,
// predicts results from a behavioral copy of the key table and slot pool.
// Depends on fwq_pkg.
`timescale 1ns / 1ps
module futex_wait_queue_engine_checker import fwq_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [1:0]            s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  m_tuser,
    input  logic                  m_tlast,
    output int                    fail_count,
    output int                    pending,
    output int                    results_seen
);

    typedef struct packed {
        logic       kind;
        logic [7:0] waiter;
        logic [2:0] status;
        logic [5:0] count;
        logic       last;
    } fwq_result_t;

    fwq_result_t expected_results[$];

    // model state
    logic        ent_vld [KEY_ENTRIES];
    key_t        ent_key [KEY_ENTRIES];
    int          ent_head[KEY_ENTRIES];
    int          ent_tail[KEY_ENTRIES];
    int          ent_len [KEY_ENTRIES];
    logic        slt_used[WAITER_SLOTS];
    logic [7:0]  slt_id  [WAITER_SLOTS];
    int          slt_next[WAITER_SLOTS];
    int          slt_ent [WAITER_SLOTS];

    function automatic void push_result(logic kind, logic [7:0] w, status_t st,
                                        int cnt, logic last);
        fwq_result_t r;
        r.kind = kind; r.waiter = w; r.status = st; r.count = cnt[5:0]; r.last = last;
        expected_results.push_back(r);
    endfunction

    function automatic int lookup_key(key_t k);
        for (int e = 0; e < KEY_ENTRIES; e++)
            if (ent_vld[e] && ent_key[e] == k) return e;
        return -1;
    endfunction

    function automatic int lowest_free_entry();
        for (int e = 0; e < KEY_ENTRIES; e++)
            if (!ent_vld[e]) return e;
        return -1;
    endfunction

    function automatic void open_entry(int e, key_t k);
        ent_vld[e] = 1; ent_key[e] = k; ent_head[e] = 0; ent_tail[e] = 0; ent_len[e] = 0;
    endfunction

    function automatic void link_tail(int e, int s);
        slt_next[s] = 0;
        slt_ent[s] = e;
        if (ent_len[e] == 0) ent_head[e] = s;
        else slt_next[ent_tail[e]] = s;
        ent_tail[e] = s;
        ent_len[e]++;
    endfunction

    function automatic int unlink_head(int e);
        int s;
        s = ent_head[e];
        ent_head[e] = slt_next[s];
        ent_len[e]--;
        if (ent_len[e] == 0) ent_vld[e] = 0;
        return s;
    endfunction

    function automatic longint release_waiters(int e, logic [31:0] lim);
        longint woken;
        int s;
        woken = 0;
        while (woken < lim && ent_vld[e] && ent_len[e] != 0) begin
            s = unlink_head(e);
            slt_used[s] = 0;
            woken++;
            push_result(1'b0, slt_id[s], STS_OK, int'(woken), 1'b0);
        end
        return woken;
    endfunction

    // predict results of one command transaction
    function automatic void predict_command(cmd_t cmd, in_data_t d);
        key_t    src, tgt;
        status_t st;
        int      e, t, fs, prev, cur;
        longint  woken, moved, len, rest, migrate;
        logic    same;
        src = '{d.key_kind, d.key_space, d.key_offset};
        tgt = '{d.target_kind, d.target_space, d.target_offset};
        case (cmd)
            CMD_WAIT: begin
                st = STS_OK;
                if (d.observed_value != d.expected_value) st = STS_MISMATCH;
                else begin
                    for (int s = 0; s < WAITER_SLOTS; s++)
                        if (slt_used[s] && slt_id[s] == d.waiter_id) st = STS_DUPLICATE;
                    if (st == STS_OK) begin
                        fs = -1;
                        for (int s = WAITER_SLOTS - 1; s >= 0; s--)
                            if (!slt_used[s]) fs = s;
                        e = lookup_key(src);
                        if (e < 0) e = lowest_free_entry();
                        if (fs < 0 || e < 0) st = STS_NO_ROOM;
                        else begin
                            if (!ent_vld[e]) open_entry(e, src);
                            slt_used[fs] = 1;
                            slt_id[fs] = d.waiter_id;
                            link_tail(e, fs);
                        end
                    end
                end
                push_result(1'b1, 8'd0, st, 0, 1'b1);
            end
            CMD_WAKE: begin
                woken = 0;
                e = lookup_key(src);
                if (e >= 0) woken = release_waiters(e, d.wake_limit);
                push_result(1'b1, 8'd0, STS_OK, int'(woken), 1'b1);
            end
            CMD_REQUEUE: begin
                e = lookup_key(src);
                if (e < 0) begin
                    push_result(1'b1, 8'd0, STS_OK, 0, 1'b1);
                    return;
                end
                same = (src == tgt);
                len = ent_len[e];
                rest = (len > d.wake_limit) ? len - d.wake_limit : 0;
                migrate = (rest < d.requeue_limit) ? rest : d.requeue_limit;
                t = -1;
                moved = 0;
                if (!same && migrate != 0) begin
                    t = lookup_key(tgt);
                    if (t < 0) begin
                        t = lowest_free_entry();
                        if (t < 0) begin
                            push_result(1'b1, 8'd0, STS_NO_ROOM, 0, 1'b1);
                            return;
                        end
                        open_entry(t, tgt);
                    end
                end
                woken = release_waiters(e, d.wake_limit);
                if (same) moved = migrate;
                else if (t >= 0) begin
                    while (moved < migrate && ent_vld[e] && ent_len[e] != 0) begin
                        link_tail(t, unlink_head(e));
                        moved++;
                    end
                end
                push_result(1'b1, 8'd0, STS_OK, int'(woken + moved), 1'b1);
            end
            default: begin
                for (int s = 0; s < WAITER_SLOTS; s++) begin
                    if (slt_used[s] && slt_id[s] == d.waiter_id) begin
                        e = slt_ent[s];
                        prev = -1;
                        cur = ent_head[e];
                        for (int n = 0; n < ent_len[e] && cur != s; n++) begin
                            prev = cur;
                            cur = slt_next[cur];
                        end
                        if (prev < 0) ent_head[e] = slt_next[s];
                        else slt_next[prev] = slt_next[s];
                        if (ent_tail[e] == s && prev >= 0) ent_tail[e] = prev;
                        if (ent_len[e] != 0) ent_len[e]--;
                        if (ent_len[e] == 0) ent_vld[e] = 0;
                        slt_used[s] = 0;
                        push_result(1'b1, 8'd0, STS_TIMED_OUT, 1, 1'b1);
                        return;
                    end
                end
                push_result(1'b1, 8'd0, STS_OK, 0, 1'b1);
            end
        endcase
    endfunction

    assign pending = expected_results.size();

    // predict on input transactions, compare on result transactions
    always @(posedge aclk) begin
        fwq_result_t exp_r;
        fwq_result_t got;
        if (!aresetn) begin
            expected_results.delete();
            fail_count <= 0;
            results_seen <= 0;
            for (int e = 0; e < KEY_ENTRIES; e++) begin
                ent_vld[e] = 0; ent_len[e] = 0; ent_head[e] = 0; ent_tail[e] = 0;
                ent_key[e] = '0;
            end
            for (int s = 0; s < WAITER_SLOTS; s++) begin
                slt_used[s] = 0; slt_id[s] = 0; slt_next[s] = 0; slt_ent[s] = 0;
            end
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen <= results_seen + 1;
                got.kind = m_tuser;
                got.waiter = m_tdata[7:0];
                got.status = m_tdata[10:8];
                got.count = m_tdata[16:11];
                got.last = m_tlast;
                if (expected_results.size() == 0) begin
                    $error("unexpected result transaction: tdata %h", m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got != exp_r) begin
                        if (got.kind != exp_r.kind)
                            $error("result_kind: expected %0d actual %0d", exp_r.kind, got.kind);
                        if (got.waiter != exp_r.waiter)
                            $error("woken_waiter: expected %0d actual %0d",
                                   exp_r.waiter, got.waiter);
                        if (got.status != exp_r.status)
                            $error("status: expected %0d actual %0d", exp_r.status, got.status);
                        if (got.count != exp_r.count)
                            $error("affected_count: expected %0d actual %0d",
                                   exp_r.count, got.count);
                        if (got.last != exp_r.last)
                            $error("last: expected %0d actual %0d", exp_r.last, got.last);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_command(cmd_t'(s_tuser), in_data_t'(s_tdata));
        end
    end

endmodule

// ----- sim/futex_wait_queue_engine_tb.sv -----
// Testbench top for the futex wait queue engine: drives command transactions,
// stalls the result side at random and reports the verdict.
// Depends on fwq_pkg, futex_wait_queue_engine and its checker.
`timescale 1ns / 1ps
module futex_wait_queue_engine_tb;
    import fwq_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [1:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    int                    fail_count, pending, results_seen;
    int                    idle_cycles = 0;
    int                    commands_sent = 0;
    bit                    calm = 1'b0;
    bit                    hold_off = 1'b0;
    bit                    stim_done = 1'b0;

    // small key pool so that waits, wakes and requeues meet each other
    key_t key_pool[6];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    futex_wait_queue_engine i_dut (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
    );

    futex_wait_queue_engine_checker i_checker (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
        .fail_count, .pending, .results_seen
    );

    // result side backpressure
    always @(posedge aclk) begin
        if (hold_off) m_tready <= 1'b0;
        else if (calm) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(99) >= 29);
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || hold_off) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic key_t pick_key();
        key_t k;
        if ($urandom_range(9) == 0)
            k = '{2'($urandom), {$urandom, $urandom}, {$urandom, $urandom}};
        else k = key_pool[$urandom_range(5)];
        return k;
    endfunction

    // send one command transaction, with random gaps before it
    task automatic send_command(cmd_t cmd, key_t src, key_t tgt, logic [7:0] id,
                                logic [31:0] ev, logic [31:0] ov,
                                logic [31:0] wl, logic [31:0] rl);
        in_data_t d;
        d = '0;
        d.key_kind = src.kind; d.key_space = src.space; d.key_offset = src.offset;
        d.target_kind = tgt.kind; d.target_space = tgt.space; d.target_offset = tgt.offset;
        d.waiter_id = id; d.expected_value = ev; d.observed_value = ov;
        d.wake_limit = wl; d.requeue_limit = rl;
        while (!calm && $urandom_range(99) < 29) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        s_tuser <= cmd;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        commands_sent++;
    endtask

    task automatic send_random();
        int          r;
        logic [31:0] v;
        logic [7:0]  id;
        r = $urandom_range(99);
        v = $urandom;
        id = (r % 4 == 0) ? 8'($urandom) : 8'($urandom_range(40));
        if (r < 45)
            send_command(CMD_WAIT, pick_key(), pick_key(), id, v,
                         ($urandom_range(9) == 0) ? ~v : v, $urandom, $urandom);
        else if (r < 65)
            send_command(CMD_WAKE, pick_key(), pick_key(), id, $urandom, $urandom,
                         ($urandom_range(7) == 0) ? $urandom : $urandom_range(4),
                         $urandom);
        else if (r < 85)
            send_command(CMD_REQUEUE, pick_key(), pick_key(), id, $urandom, $urandom,
                         ($urandom_range(7) == 0) ? $urandom : $urandom_range(3),
                         ($urandom_range(7) == 0) ? $urandom : $urandom_range(5));
        else
            send_command(CMD_WITHDRAW, pick_key(), pick_key(), id, $urandom, $urandom,
                         $urandom, $urandom);
    endtask

    initial begin
        key_t k0, k1, kmax;
        k0 = '{2'd0, 64'd0, 64'd0};
        k1 = '{2'd1, 64'h1000, 64'h40};
        kmax = '{2'd3, '1, '1};
        key_pool[0] = k0; key_pool[1] = k1; key_pool[2] = kmax;
        key_pool[3] = '{2'd2, 64'h5555_aaaa_5555_aaaa, 64'h8};
        key_pool[4] = '{2'd1, 64'h1000, 64'h44};
        key_pool[5] = '{2'd0, 64'h1000, 64'h40};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: field extremes, every command, the corner cases
        send_command(CMD_WAKE, k0, k0, 8'd0, 0, 0, '1, 0);          // absent key
        send_command(CMD_REQUEUE, k1, k0, 8'd0, 0, 0, 0, '1);       // absent key
        send_command(CMD_WAIT, k0, k0, 8'd0, 0, 1, 0, 0);           // mismatch
        send_command(CMD_WAIT, k0, k0, 8'd0, '1, '1, 0, 0);
        send_command(CMD_WAIT, k0, kmax, 8'd255, 0, 0, '1, '1);
        send_command(CMD_WAIT, kmax, k0, 8'd255, 7, 7, 0, 0);       // duplicate id
        send_command(CMD_WAIT, kmax, k0, 8'd17, 7, 7, 0, 0);
        send_command(CMD_WAIT, k0, k0, 8'd3, 1, 1, 0, 0);
        send_command(CMD_REQUEUE, k0, k0, 8'd0, 0, 0, 1, '1);       // same key counts
        send_command(CMD_REQUEUE, k0, kmax, 8'd0, 0, 0, 0, 1);      // move onto kmax
        send_command(CMD_WITHDRAW, k1, k1, 8'd255, 0, 0, 0, 0);     // moved waiter
        send_command(CMD_WITHDRAW, k1, k1, 8'd255, 0, 0, 0, 0);     // already gone
        send_command(CMD_WAKE, kmax, kmax, 8'd0, 0, 0, 0, 0);       // zero limit
        send_command(CMD_WAKE, kmax, kmax, 8'd0, 0, 0, '1, 0);
        send_command(CMD_WAKE, k0, k0, 8'd0, 0, 0, '1, 0);
        // fill the key table, then a requeue to a new key has no room
        for (int i = 0; i < 16; i++)
            send_command(CMD_WAIT, '{2'd2, 64'(i), 64'(i)}, k0, 8'(100 + i), 0, 0, 0, 0);
        send_command(CMD_WAIT, k1, k0, 8'd1, 0, 0, 0, 0);           // table full
        send_command(CMD_WAIT, '{2'd2, 64'd0, 64'd0}, k0, 8'd2, 0, 0, 0, 0);
        send_command(CMD_REQUEUE, '{2'd2, 64'd0, 64'd0}, k1, 8'd0, 0, 0, 0, 4);
        for (int i = 0; i < 16; i++)
            send_command(CMD_WAKE, '{2'd2, 64'(i), 64'(i)}, k0, 8'd0, 0, 0, '1, 0);
        // fill the slot pool on one key, then one more waiter has no room
        for (int i = 0; i < 33; i++)
            send_command(CMD_WAIT, k1, k0, 8'(i), 0, 0, 0, 0);
        send_command(CMD_WAKE, k1, k1, 8'd0, 0, 0, '1, 0);          // 32 reports

        // random part, with one calm stretch and one long receiver hold-off
        for (int n = 0; n < 66; n++) begin
            calm = (n >= 20 && n < 40);
            if (n == 50) hold_off = 1'b1;
            send_random();
        end
        s_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // long receiver hold-off while the sender keeps offering
    initial begin
        wait (hold_off);
        repeat (400) @(posedge aclk);
        hold_off = 1'b0;
    end

    // verdict once everything has drained
    initial begin
        wait (stim_done);
        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        $display("covered %0d commands of every kind with %0d result transactions",
                 commands_sent, results_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
